// ----- sv/lob_pkg.sv -----
// Package of types and constants shared by the limit order book.
package lob_pkg;

  localparam int unsigned MAX_ORDERS = 64;
  localparam int unsigned SLOT_W = $clog2(MAX_ORDERS);

  // Operation codes.
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_FILL   = 2'd2;
  // Code with no operation; the book is left as it is.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_DUP     = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] already_filled;
    logic [31:0] fill_amount;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        order_removed;
    logic        out_side;
    logic [31:0] out_price;
    logic [31:0] out_quantity;
    logic [31:0] out_filled;
    logic        best_bid_valid;
    logic [31:0] high_bid;
    logic        best_ask_valid;
    logic [31:0] low_ask;
  } out_word_t;

  // One slot entry as stored in the order memory.
  typedef struct packed {
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] filled;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_BEST,
    ST_SEND
  } fsm_t;

endpackage

// ----- sv/limit_order_book.sv -----
// Top level of the limit order book: slot memory, scan sequencer and result register.
//
// Usage: one input word on in_valid/in_stall/in_data carries an operation (add,
// cancel by id, fill). Each input word yields exactly one result word on
// out_valid/out_stall/out_data holding status, the affected order and the best
// bid and ask after the operation.
// Orders are held in a MAX_ORDERS-entry memory with a registered read port.
// Valid marks live in flip-flops and are cleared by reset at once, so no
// clearing pass is needed. After an input word is accepted, a lookup pass
// finds the id and the lowest free slot, the change is written back, a
// best-price pass recomputes the best prices and the result is loaded; the
// passes run one after the other on the single memory read port.
// One word is processed at a time; in_stall is high while the block is busy.
// The result stays in the output register until out_stall is low; the block
// waits on it before taking the next word. Reset empties the book and drops
// any word in progress.
module limit_order_book (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lob_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lob_pkg::out_word_t out_data
);

  localparam int unsigned SW = lob_pkg::SLOT_W;

  lob_pkg::slot_t mem [lob_pkg::MAX_ORDERS];
  logic [lob_pkg::MAX_ORDERS-1:0] valid_r, valid_nxt;

  lob_pkg::fsm_t state_r, state_nxt;
  lob_pkg::in_word_t req_r, req_nxt;
  logic [SW:0]  cnt_r, cnt_nxt;     // read address counter, one extra bit for end
  logic [SW-1:0] rd_idx_r;          // slot index of the data in rd_data_r
  logic          rd_live_r;         // rd_data_r holds a slot read this pass
  lob_pkg::slot_t rd_data_r;
  logic          hit_r, hit_nxt;
  logic [SW-1:0] hit_idx_r, hit_idx_nxt;
  lob_pkg::slot_t hit_slot_r, hit_slot_nxt;
  logic          free_ok_r, free_ok_nxt;
  logic [SW-1:0] free_idx_r, free_idx_nxt;
  logic          bid_ok_r, bid_ok_nxt, ask_ok_r, ask_ok_nxt;
  logic [31:0]   bid_r, bid_nxt, ask_r, ask_nxt;
  lob_pkg::out_word_t res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          wr_en;
  logic [SW-1:0] wr_idx;
  lob_pkg::slot_t wr_data;
  logic          rd_en;
  logic [32:0]   fill_sum;
  logic [31:0]   fill_sat;

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[cnt_r[SW-1:0]];
    end
  end

  assign rd_en = (state_r == lob_pkg::ST_SCAN || state_r == lob_pkg::ST_BEST)
                 && !cnt_r[SW];

  // Saturating fill sum on the matched order.
  assign fill_sum = {1'b0, hit_slot_r.filled} + {1'b0, req_r.fill_amount};
  assign fill_sat = fill_sum[32] ? 32'hFFFF_FFFF : fill_sum[31:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lob_pkg::ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      rd_live_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      rd_live_r   <= rd_en;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cnt_r      <= cnt_nxt;
    rd_idx_r   <= cnt_r[SW-1:0];
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_slot_r <= hit_slot_nxt;
    free_ok_r  <= free_ok_nxt;
    free_idx_r <= free_idx_nxt;
    bid_ok_r   <= bid_ok_nxt;
    ask_ok_r   <= ask_ok_nxt;
    bid_r      <= bid_nxt;
    ask_r      <= ask_nxt;
    res_r      <= res_nxt;
  end

  // Sequencer: lookup pass, write-back, best-price pass, result.
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_slot_nxt  = hit_slot_r;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    bid_ok_nxt    = bid_ok_r;
    ask_ok_nxt    = ask_ok_r;
    bid_nxt       = bid_r;
    ask_nxt       = ask_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_idx        = hit_idx_r;
    wr_data       = hit_slot_r;
    in_stall      = 1'b1;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lob_pkg::ST_IDLE: begin
        in_stall = out_valid_r;
        if (in_valid && !out_valid_r) begin
          req_nxt     = in_data;
          cnt_nxt     = '0;
          hit_nxt     = 1'b0;
          free_ok_nxt = 1'b0;
          state_nxt   = lob_pkg::ST_SCAN;
        end
      end

      lob_pkg::ST_SCAN: begin
        // Free slot search uses valid marks directly; id match uses memory data.
        if (!cnt_r[SW]) begin
          if (!free_ok_r && !valid_r[cnt_r[SW-1:0]]) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = cnt_r[SW-1:0];
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rd_live_r && !hit_r && valid_r[rd_idx_r] && rd_data_r.id == req_r.order_id) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = rd_idx_r;
          hit_slot_nxt = rd_data_r;
        end
        if (cnt_r[SW] && !rd_live_r) begin
          state_nxt = lob_pkg::ST_APPLY;
        end
      end

      lob_pkg::ST_APPLY: begin
        res_nxt = '0;
        case (req_r.func)
          lob_pkg::FUNC_ADD: begin
            if (hit_r) begin
              res_nxt.status       = lob_pkg::ST_DUP;
              res_nxt.out_side     = hit_slot_r.side;
              res_nxt.out_price    = hit_slot_r.price;
              res_nxt.out_quantity = hit_slot_r.quantity;
              res_nxt.out_filled   = hit_slot_r.filled;
            end else if (!free_ok_r) begin
              res_nxt.status = lob_pkg::ST_FULL;
            end else begin
              wr_en                = 1'b1;
              wr_idx               = free_idx_r;
              wr_data.id           = req_r.order_id;
              wr_data.side         = req_r.side;
              wr_data.price        = req_r.price;
              wr_data.quantity     = req_r.quantity;
              wr_data.filled       = req_r.already_filled;
              valid_nxt[free_idx_r] = 1'b1;
              res_nxt.out_side     = req_r.side;
              res_nxt.out_price    = req_r.price;
              res_nxt.out_quantity = req_r.quantity;
              res_nxt.out_filled   = req_r.already_filled;
            end
          end
          lob_pkg::FUNC_CANCEL: begin
            if (!hit_r) begin
              res_nxt.status = lob_pkg::ST_UNKNOWN;
            end else begin
              valid_nxt[hit_idx_r]  = 1'b0;
              res_nxt.order_removed = 1'b1;
              res_nxt.out_side      = hit_slot_r.side;
              res_nxt.out_price     = hit_slot_r.price;
              res_nxt.out_quantity  = hit_slot_r.quantity;
              res_nxt.out_filled    = hit_slot_r.filled;
            end
          end
          lob_pkg::FUNC_FILL: begin
            if (!hit_r) begin
              res_nxt.status = lob_pkg::ST_UNKNOWN;
            end else begin
              wr_en                = 1'b1;
              wr_data.filled       = fill_sat;
              res_nxt.out_side     = hit_slot_r.side;
              res_nxt.out_price    = hit_slot_r.price;
              res_nxt.out_quantity = hit_slot_r.quantity;
              res_nxt.out_filled   = fill_sat;
              if (fill_sat >= hit_slot_r.quantity) begin
                valid_nxt[hit_idx_r]  = 1'b0;
                res_nxt.order_removed = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        cnt_nxt    = '0;
        bid_ok_nxt = 1'b0;
        ask_ok_nxt = 1'b0;
        bid_nxt    = '0;
        ask_nxt    = '0;
        state_nxt  = lob_pkg::ST_BEST;
      end

      lob_pkg::ST_BEST: begin
        if (!cnt_r[SW]) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rd_live_r && valid_r[rd_idx_r]) begin
          if (!rd_data_r.side) begin
            if (!bid_ok_r || rd_data_r.price > bid_r) begin
              bid_nxt = rd_data_r.price;
            end
            bid_ok_nxt = 1'b1;
          end else begin
            if (!ask_ok_r || rd_data_r.price < ask_r) begin
              ask_nxt = rd_data_r.price;
            end
            ask_ok_nxt = 1'b1;
          end
        end
        if (cnt_r[SW] && !rd_live_r) begin
          state_nxt = lob_pkg::ST_SEND;
        end
      end

      lob_pkg::ST_SEND: begin
        res_nxt.best_bid_valid = bid_ok_r;
        res_nxt.high_bid       = bid_r;
        res_nxt.best_ask_valid = ask_ok_r;
        res_nxt.low_ask        = ask_r;
        out_valid_nxt          = 1'b1;
        state_nxt              = lob_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = lob_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // A result word is only raised from the final sequencer step.
  a_out_from_send: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == lob_pkg::ST_SEND))
    else $error("result raised outside the send step");

  // No new word is taken while a result waits.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted with a result pending");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Best flags track whether any valid slot exists.
  a_best_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lob_pkg::ST_SEND && valid_r == '0) |-> (!bid_ok_r && !ask_ok_r))
    else $error("best price reported on an empty book");

endmodule

// ----- test/limit_order_book_tb.sv -----
// Testbench for the limit order book: directed and random order streams checked against a predictor.
module limit_order_book_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_IDS = 96;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lob_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lob_pkg::out_word_t out_data;

  // Predictor copy of the order table.
  logic        book_valid [lob_pkg::MAX_ORDERS];
  logic [31:0] book_id [lob_pkg::MAX_ORDERS];
  logic        book_side [lob_pkg::MAX_ORDERS];
  logic [31:0] book_price [lob_pkg::MAX_ORDERS];
  logic [31:0] book_qty [lob_pkg::MAX_ORDERS];
  logic [31:0] book_filled [lob_pkg::MAX_ORDERS];

  lob_pkg::out_word_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int orders_sent = 0;
  int idle_pct = 25;
  bit hold_receiver = 1'b0;

  limit_order_book dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Work out the result of one operation and update the predicted book.
  function automatic lob_pkg::out_word_t book_apply(lob_pkg::in_word_t w);
    lob_pkg::out_word_t r;
    int hit;
    int free_slot;
    logic [32:0] sum;
    r = '0;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < lob_pkg::MAX_ORDERS; i++) begin
      if (book_valid[i] && book_id[i] == w.order_id && hit < 0) hit = i;
      if (!book_valid[i] && free_slot < 0) free_slot = i;
    end
    case (w.func)
      lob_pkg::FUNC_ADD: begin
        if (hit >= 0) begin
          r.status = lob_pkg::ST_DUP;
        end else if (free_slot < 0) begin
          r.status = lob_pkg::ST_FULL;
        end else begin
          hit = free_slot;
          book_valid[hit] = 1'b1;
          book_id[hit] = w.order_id;
          book_side[hit] = w.side;
          book_price[hit] = w.price;
          book_qty[hit] = w.quantity;
          book_filled[hit] = w.already_filled;
          r.status = lob_pkg::ST_OK;
        end
        if (r.status != lob_pkg::ST_FULL) begin
          r.out_side = book_side[hit];
          r.out_price = book_price[hit];
          r.out_quantity = book_qty[hit];
          r.out_filled = book_filled[hit];
        end
      end
      lob_pkg::FUNC_CANCEL, lob_pkg::FUNC_FILL: begin
        if (hit < 0) begin
          r.status = lob_pkg::ST_UNKNOWN;
        end else begin
          r.status = lob_pkg::ST_OK;
          if (w.func == lob_pkg::FUNC_FILL) begin
            sum = {1'b0, book_filled[hit]} + {1'b0, w.fill_amount};
            book_filled[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
          r.out_side = book_side[hit];
          r.out_price = book_price[hit];
          r.out_quantity = book_qty[hit];
          r.out_filled = book_filled[hit];
          if (w.func == lob_pkg::FUNC_CANCEL || book_filled[hit] >= book_qty[hit]) begin
            r.order_removed = 1'b1;
            book_valid[hit] = 1'b0;
          end
        end
      end
      default: r.status = lob_pkg::ST_OK;
    endcase
    // Best prices over everything still resting.
    for (int i = 0; i < lob_pkg::MAX_ORDERS; i++) begin
      if (book_valid[i]) begin
        if (book_side[i] == 1'b0) begin
          if (!r.best_bid_valid || book_price[i] > r.high_bid)
            r.high_bid = book_price[i];
          r.best_bid_valid = 1'b1;
        end else begin
          if (!r.best_ask_valid || book_price[i] < r.low_ask)
            r.low_ask = book_price[i];
          r.best_ask_valid = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Send one word, with a random idle gap first. The task returns after the
  // accepting edge, with valid already low.
  task automatic send_word(lob_pkg::in_word_t w);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clk);
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.insert(expected_results.size(), book_apply(w));
    orders_sent++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic lob_pkg::in_word_t make_word(logic [1:0] f, logic [31:0] id, logic sd,
                                                  logic [31:0] pr, logic [31:0] q,
                                                  logic [31:0] pf, logic [31:0] fa);
    lob_pkg::in_word_t w;
    w.func = f; w.order_id = id; w.side = sd; w.price = pr;
    w.quantity = q; w.already_filled = pf; w.fill_amount = fa;
    return w;
  endfunction

  // Receiver stall generator.
  always @(posedge clk) begin
    if (hold_receiver) out_stall <= 1'b1;
    else out_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %h", out_data);
      end else begin
        lob_pkg::out_word_t e;
        e = expected_results.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h, got %h", e, out_data);
        end
      end
    end
  end

  // Extremes of every field, every operation and the special cases.
  task automatic test_directed();
    send_word(make_word(lob_pkg::FUNC_CANCEL, 32'd5, 1'b0, '0, '0, '0, '0));
    send_word(make_word(lob_pkg::FUNC_FILL, 32'hFFFF_FFFF, 1'b1, '0, '0, '0, 32'd1));
    send_word(make_word(lob_pkg::FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, '1, '1, '1, '1));
    send_word(make_word(lob_pkg::FUNC_ADD, 32'd0, 1'b0, 32'd0, 32'd10, 32'd0, '0));
    send_word(make_word(lob_pkg::FUNC_ADD, 32'hFFFF_FFFF, 1'b1, '1, '1, '1, '1));
    send_word(make_word(lob_pkg::FUNC_ADD, 32'd0, 1'b1, 32'd7, 32'd7, 32'd7, '0));
    send_word(make_word(lob_pkg::FUNC_ADD, 32'd2, 1'b0, '1, 32'd5, 32'd9, '0));
    send_word(make_word(lob_pkg::FUNC_UNUSED, 32'd2, 1'b0, '0, '0, '0, '0));
    send_word(make_word(lob_pkg::FUNC_FILL, 32'd2, 1'b0, '0, '0, '0, 32'd0));
    send_word(make_word(lob_pkg::FUNC_FILL, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, '1));
    send_word(make_word(lob_pkg::FUNC_FILL, 32'd0, 1'b0, '0, '0, '0, 32'd4));
    send_word(make_word(lob_pkg::FUNC_ADD, 32'd3, 1'b1, 32'd1, '1, 32'hFFFF_FFF0, '0));
    send_word(make_word(lob_pkg::FUNC_FILL, 32'd3, 1'b0, '0, '0, '0, '1));
    send_word(make_word(lob_pkg::FUNC_FILL, 32'd0, 1'b0, '0, '0, '0, 32'd6));
    send_word(make_word(lob_pkg::FUNC_CANCEL, 32'd0, 1'b0, '0, '0, '0, '0));
  endtask

  // Fill the table until it overflows, then empty it by cancels.
  task automatic test_full_table();
    for (int i = 0; i <= lob_pkg::MAX_ORDERS + 1; i++)
      send_word(make_word(lob_pkg::FUNC_ADD, 32'h1000 + i, i[0], $urandom, 32'd100,
                          32'd0, '0));
    for (int i = 0; i <= lob_pkg::MAX_ORDERS; i++)
      send_word(make_word(lob_pkg::FUNC_CANCEL, 32'h1000 + i, 1'b0, '0, '0, '0, '0));
  endtask

  // Receiver holds off while the sender keeps offering words.
  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1'b1;
        repeat (600) @(posedge clk);
        hold_receiver = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_word(make_word(lob_pkg::FUNC_ADD, 32'h2000 + i, i[0], $urandom, $urandom,
                            '0, '0));
    join
  endtask

  // Random stream over a small id pool so that hits are common.
  task automatic test_random(int count, int pct);
    lob_pkg::in_word_t w;
    int pick;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      w = make_word(lob_pkg::FUNC_ADD, $urandom_range(MAX_IDS - 1), 1'($urandom_range(1)),
                    $urandom, $urandom_range(1000), $urandom_range(200), $urandom_range(600));
      if ($urandom_range(9) == 0) begin
        w.order_id = $urandom;
        w.price = $urandom;
        w.quantity = $urandom;
        w.already_filled = $urandom;
        w.fill_amount = $urandom;
      end
      if (pick < 45) w.func = lob_pkg::FUNC_ADD;
      else if (pick < 65) w.func = lob_pkg::FUNC_CANCEL;
      else if (pick < 95) w.func = lob_pkg::FUNC_FILL;
      else w.func = lob_pkg::FUNC_UNUSED;
      send_word(w);
    end
    idle_pct = 25;
  endtask

  initial begin
    for (int i = 0; i < lob_pkg::MAX_ORDERS; i++) begin
      book_valid[i] = 1'b0;
      book_id[i] = '0; book_side[i] = 1'b0; book_price[i] = '0;
      book_qty[i] = '0; book_filled[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(100, 25);
    test_random(80, 0);
    test_random(70, 25);
    idle_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d order words (adds, cancels, fills, unused code, full table, long stall).",
             orders_sent);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/lob_pkg.sv
sv/limit_order_book.sv
test/limit_order_book_tb.sv
